[sv/bspl_pkg.sv]
package bspl_pkg;

   // Table geometry and field widths
   localparam int unsigned TABLE_SIZE     = 4096;
   localparam int unsigned IDX_W          = 12;
   localparam int unsigned CNT_W          = 13;
   localparam int unsigned COORD_W        = 32;
   localparam int unsigned LEAF_FLAG_BIT  = 13;
   localparam int unsigned CHILD_W        = LEAF_FLAG_BIT + 1;
   localparam int unsigned SUB_W          = 13;
   localparam int unsigned NODE_DEPTH_DEF = 4096;

   // Leaf flag inside a child link
   localparam logic [CHILD_W-1:0] LEAF_LINK_FLAG = CHILD_W'(1) << LEAF_FLAG_BIT;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        CSR_REG_NODE_COUNT = 1'b0;
   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(1);

   // Item actions
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOCATE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_FOUND = 2'd0,
      STATUS_WRITE = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic                      action;
      logic [IDX_W-1:0]          node_index;
      logic signed [COORD_W-1:0] line_x;
      logic signed [COORD_W-1:0] line_y;
      logic signed [COORD_W-1:0] line_dx;
      logic signed [COORD_W-1:0] line_dy;
      logic [CHILD_W-1:0]        front_child;
      logic [CHILD_W-1:0]        back_child;
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
   } req_type;

   typedef struct packed {
      logic [SUB_W-1:0] subsector_index;
      logic [1:0]       status;
   } rsp_type;

   // One table entry
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] dx;
      logic signed [COORD_W-1:0] dy;
      logic [CHILD_W-1:0]        front;
      logic [CHILD_W-1:0]        back;
   } node_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CHECK,
      ST_DIFF,
      ST_MUL,
      ST_DECIDE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       write_node;
      logic       read_node;
      logic       calc_diff;
      logic       calc_prod;
      logic       step;
      logic       emit;
      status_type emit_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic node_bad;
      logic leaf;
   } sts_type;

endpackage

[sv/bspl_ctrl.sv]
module bspl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              action,
   input  bspl_pkg::sts_type sts,
   output bspl_pkg::cmd_type cmd,
   output logic              busy
);
   import bspl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (action == ACT_WRITE) ? ST_WRITE : ST_CHECK;
            end
         end
         ST_WRITE:  state_in = ST_IDLE;
         ST_CHECK:  state_in = sts.node_bad ? ST_IDLE : ST_DIFF;
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_DECIDE;
         ST_DECIDE: state_in = sts.leaf ? ST_IDLE : ST_CHECK;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd             = '0;
      cmd.emit_status = STATUS_FOUND;
      busy            = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_WRITE: begin
            cmd.write_node  = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_status = STATUS_WRITE;
         end
         ST_CHECK: begin
            if (sts.node_bad) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STATUS_ERROR;
            end else begin
               cmd.read_node = 1'b1;
            end
         end
         ST_DIFF: cmd.calc_diff = 1'b1;
         ST_MUL:  cmd.calc_prod = 1'b1;
         ST_DECIDE: begin
            if (sts.leaf) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = STATUS_FOUND;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

[sv/bspl_dpath.sv]
module bspl_dpath #(
   parameter int unsigned NODE_DEPTH = bspl_pkg::NODE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bspl_pkg::req_type             req_data,
   input  logic [bspl_pkg::CNT_W-1:0]    node_count,
   input  bspl_pkg::cmd_type             cmd,
   output bspl_pkg::sts_type             sts,
   output logic                          rsp_strobe,
   output bspl_pkg::rsp_type             rsp_data
);
   import bspl_pkg::*;

   localparam int unsigned VISIT_W = $clog2(NODE_DEPTH + 1);
   localparam logic [VISIT_W-1:0] VISIT_LIMIT = VISIT_W'(NODE_DEPTH);
   localparam int unsigned PROD_W = 2 * COORD_W;
   localparam int unsigned FRAC_BITS = 16;

   node_type mem [TABLE_SIZE];

   req_type                   item_ff, item_in;
   logic [CNT_W-1:0]          cur_ff, cur_in;
   logic [VISIT_W-1:0]        visits_ff, visits_in;
   node_type                  node_ff;
   logic signed [COORD_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [PROD_W-1:0]  prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      strobe_ff, strobe_in;

   logic               side;
   logic [CHILD_W-1:0] link;
   logic               mix_sign;

   // Node table, written by write items and read one entry per walk step
   always_ff @(posedge clock) begin
      if (cmd.write_node) begin
         mem[item_ff.node_index] <= '{x: item_ff.line_x, y: item_ff.line_y,
                                     dx: item_ff.line_dx, dy: item_ff.line_dy,
                                     front: item_ff.front_child,
                                     back: item_ff.back_child};
      end
      if (cmd.read_node) begin
         node_ff <= mem[cur_ff[IDX_W-1:0]];
      end
   end

   // Side test on the fetched node
   always_comb begin
      mix_sign = node_ff.dy[COORD_W-1] ^ node_ff.dx[COORD_W-1] ^
                 rx_ff[COORD_W-1] ^ ry_ff[COORD_W-1];
      if (node_ff.dx == '0) begin
         side = (item_ff.query_x <= node_ff.x) ? (node_ff.dy > 0) : (node_ff.dy < 0);
      end else if (node_ff.dy == '0) begin
         side = (item_ff.query_y <= node_ff.y) ? (node_ff.dx < 0) : (node_ff.dx > 0);
      end else if (mix_sign) begin
         side = node_ff.dy[COORD_W-1] ^ rx_ff[COORD_W-1];
      end else begin
         side = (prod_a_ff >>> FRAC_BITS) >= (prod_b_ff >>> FRAC_BITS);
      end
      link = side ? node_ff.back : node_ff.front;
   end

   // Status to the controller
   always_comb begin
      sts.node_bad = (visits_ff == VISIT_LIMIT) || (cur_ff >= node_count) ||
                     (cur_ff >= CNT_W'(TABLE_SIZE));
      sts.leaf     = (link & LEAF_LINK_FLAG) != '0;
   end

   // Next values of the walk registers
   always_comb begin
      item_in   = item_ff;
      cur_in    = cur_ff;
      visits_in = visits_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      rsp_in    = rsp_ff;
      strobe_in = cmd.emit;
      if (cmd.capture) begin
         item_in   = req_data;
         cur_in    = node_count - CNT_W'(1);
         visits_in = '0;
      end
      if (cmd.calc_diff) begin
         rx_in = item_ff.query_x - node_ff.x;
         ry_in = item_ff.query_y - node_ff.y;
      end
      if (cmd.calc_prod) begin
         prod_a_in = PROD_W'(ry_ff) * PROD_W'(node_ff.dx);
         prod_b_in = PROD_W'(node_ff.dy) * PROD_W'(rx_ff);
      end
      if (cmd.step) begin
         cur_in    = CNT_W'(link[LEAF_FLAG_BIT-1:0]);
         visits_in = visits_ff + VISIT_W'(1);
      end
      if (cmd.emit) begin
         rsp_in.status = cmd.emit_status;
         rsp_in.subsector_index = (cmd.emit_status == STATUS_FOUND) ?
                                  SUB_W'(link[LEAF_FLAG_BIT-1:0]) : '0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      cur_ff    <= cur_in;
      visits_ff <= visits_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      rsp_ff    <= rsp_in;
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[sv/bsp_point_locator.sv]
// Binary space partition point locator.
// Software first loads the node table: an item with action 0 writes one
// entry and answers with status 1. An item with action 1 walks the tree
// from node node_count-1 and answers with the leaf's subsector index and
// status 0, or status 2 when the walk leaves the table or exceeds
// NODE_DEPTH nodes. An item is taken at a clock edge where start is high
// and busy is low; every item gives exactly one result, shown for one
// cycle with rsp_strobe high. The receiver cannot stall the block.
// For a query, each node visited costs one table read, one subtract,
// one pair of 32x32 multiplies and one compare, in that order, all
// sequenced through a single shared datapath. busy falls in the cycle
// the result is shown, so the next item may be taken then. node_count
// lives on the register port and must only be written while the block
// is idle. Reset returns the controller to idle, drops any strobe and
// sets node_count to 1; table contents are not cleared and an entry
// must be written before a query reads it.
module bsp_point_locator #(
   parameter int unsigned NODE_DEPTH = bspl_pkg::NODE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bspl_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output bspl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bspl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bspl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bspl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import bspl_pkg::*;

   logic [CNT_W-1:0] node_count_ff, node_count_in;
   logic             csr_hit;
   cmd_type          cmd;
   sts_type          sts;

   // Register port: single node_count register, seen at offsets 0 to 3
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_REG_NODE_COUNT);

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         node_count_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(node_count_ff) : '0;

   bspl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   bspl_dpath #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .node_count (node_count_ff),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // An accepted item always keeps the block busy for the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting an item");

   // Results are never shown in consecutive cycles.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A result only follows a cycle in which an item was in progress.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result shown with no item in progress");

   // Writes and errors carry a zero subsector index.
   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != STATUS_FOUND)) |->
      (rsp_data.subsector_index == '0))
      else $error("nonzero subsector index on a write or error result");

endmodule
